### design/hth_pkg.sv
package hth_pkg;

    // Table and counter geometry
    localparam int TABLE_DEPTH = 131072;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_WIDTH = 24;

    // Field widths at the ports
    localparam int CHAR_W   = 8;
    localparam int SLOT_W   = 17;
    localparam int OUT_CW   = 24;
    localparam int TOTAL_W  = 32;
    localparam int UNIQUE_W = 17;

    // Stream data widths, padded to whole bytes
    localparam int IN_TDATA_W  = CHAR_W;
    localparam int OUT_FIELD_W = SLOT_W + OUT_CW + TOTAL_W + UNIQUE_W + OUT_CW + SLOT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Hash modulus; the multiply by 54 is done as shifts and adds
    localparam int HASH_MOD = 99999;

    // Pre-reduction value acc*54 + char is below 2^23
    localparam int V_W         = 23;
    localparam int RED_SHIFT   = 15;
    localparam int RED_IDX_W   = V_W - RED_SHIFT;
    localparam int RED_ENTRIES = 1 << RED_IDX_W;
    localparam int RED_STEP    = 1 << RED_SHIFT;

    typedef logic [V_W-1:0] red_tab_t [RED_ENTRIES];

    // Largest multiple of the modulus not above each coarse bucket start
    function automatic red_tab_t build_red_tab();
        red_tab_t t;
        for (int i = 0; i < RED_ENTRIES; i++)
        begin
            t[i] = V_W'((i * RED_STEP / HASH_MOD) * HASH_MOD);
        end
        return t;
    endfunction

    localparam red_tab_t RED_TAB = build_red_tab();

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

endpackage

### design/hashed_token_histogram_top.sv
// Hashed token histogram. Characters arrive one per beat on the slave stream, the last
// character of a token marked by tlast. A polynomial hash (acc*54 + char mod 99999) picks a
// slot in a 131072-entry count table held in a single-port-per-direction synchronous RAM.
// Each finished token produces one result beat with the slot, its new saturating count, a
// first-seen flag in tuser, and the running token total, unique-slot count and top record.
// After reset the block clears the table, one entry per cycle, with s_axis_tready low.
// After that one character is taken every cycle unless the input stalls; a token's result
// passes through the read register, update stage and output register, and a back-to-back
// read-modify-write on the same slot is forwarded. The input stalls only while a result
// sits in the table update stage and the output register is full and not being taken.
module hashed_token_histogram_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] char_code
    input  logic [hth_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [16:0] slot, [40:17] slot_count, [72:41] total_tokens, [89:73] unique_tokens,
    // [113:90] top_count, [130:114] top_slot, [135:131] zero
    output logic [hth_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] first_seen
    output logic                            m_axis_tuser
);
    import hth_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0]     TOTAL_MAX = '1;

    // Control and state registers
    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      clr_addr_reg, clr_addr_next;
    logic [SLOT_W-1:0]      hash_acc_reg, hash_acc_next;
    logic                   s2_valid_reg, s2_valid_next;
    logic [SLOT_W-1:0]      s2_slot_reg, s2_slot_next;
    logic                   fwd_hit_reg, fwd_hit_next;
    logic [COUNT_WIDTH-1:0] fwd_data_reg, fwd_data_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic [UNIQUE_W-1:0]    unique_reg, unique_next;
    logic [COUNT_WIDTH-1:0] best_count_reg, best_count_next;
    logic [SLOT_W-1:0]      best_slot_reg, best_slot_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]      out_slot_reg, out_slot_next;
    logic [OUT_CW-1:0]      out_count_reg, out_count_next;
    logic                   out_first_reg, out_first_next;
    logic [TOTAL_W-1:0]     out_total_reg, out_total_next;
    logic [UNIQUE_W-1:0]    out_unique_reg, out_unique_next;
    logic [OUT_CW-1:0]      out_top_count_reg, out_top_count_next;
    logic [SLOT_W-1:0]      out_top_slot_reg, out_top_slot_next;

    // Count table
    logic [COUNT_WIDTH-1:0] count_mem [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;

    // Datapath
    logic                   running;
    logic                   in_fire;
    logic                   s2_fire;
    logic                   s2_stall;
    logic [V_W-1:0]         acc_ext;
    logic [V_W-1:0]         hash_v;
    logic [RED_IDX_W-1:0]   red_idx;
    logic [SLOT_W:0]        rem_raw;
    logic [SLOT_W:0]        rem_sub;
    logic [SLOT_W-1:0]      hash_new;
    logic [COUNT_WIDTH-1:0] cnt_old;
    logic [COUNT_WIDTH-1:0] cnt_new;
    logic                   can_inc;
    logic                   first;
    logic [TOTAL_W-1:0]     total_upd;
    logic [UNIQUE_W-1:0]    unique_upd;
    logic [COUNT_WIDTH-1:0] best_count_upd;
    logic [SLOT_W-1:0]      best_slot_upd;
    logic [31:0]            cnt_wide;
    logic [31:0]            best_wide;

    assign running = (state_reg == ST_RUN);

    // Handshake
    assign s2_fire       = s2_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s2_stall      = s2_valid_reg && !s2_fire;
    assign s_axis_tready = running && !s2_stall;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Hash step: acc*54 + char, then reduce with a coarse table and one correction
    assign acc_ext  = V_W'(hash_acc_reg);
    assign hash_v   = (acc_ext << 5) + (acc_ext << 4) + (acc_ext << 2) + (acc_ext << 1)
                    + V_W'(s_axis_tdata[CHAR_W-1:0]);
    assign red_idx  = hash_v[V_W-1:RED_SHIFT];
    assign rem_raw  = (SLOT_W+1)'(hash_v - RED_TAB[red_idx]);
    assign rem_sub  = rem_raw - (SLOT_W+1)'(HASH_MOD);
    assign hash_new = (rem_raw >= (SLOT_W+1)'(HASH_MOD)) ? rem_sub[SLOT_W-1:0]
                                                        : rem_raw[SLOT_W-1:0];

    // Table update stage
    assign cnt_old = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign can_inc = (cnt_old != COUNT_MAX);
    assign cnt_new = can_inc ? cnt_old + COUNT_WIDTH'(1) : cnt_old;
    assign first   = can_inc && (cnt_old == '0);

    assign total_upd  = (total_reg != TOTAL_MAX) ? total_reg + TOTAL_W'(1) : total_reg;
    assign unique_upd = first ? unique_reg + UNIQUE_W'(1) : unique_reg;

    always_comb
    begin
        best_count_upd = best_count_reg;
        best_slot_upd  = best_slot_reg;
        if (cnt_new > best_count_reg)
        begin
            best_count_upd = cnt_new;
            best_slot_upd  = s2_slot_reg;
        end
    end

    assign cnt_wide  = 32'(cnt_new);
    assign best_wide = 32'(best_count_upd);

    // Memory port selection
    always_comb
    begin
        if (running)
        begin
            mem_we    = s2_fire && can_inc;
            mem_waddr = ADDR_W'(s2_slot_reg);
            mem_wdata = cnt_new;
        end
        else
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
    end

    assign mem_re    = in_fire && s_axis_tlast;
    assign mem_raddr = ADDR_W'(hash_new);

    // Count table RAM, read-first
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            count_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= count_mem[mem_raddr];
        end
    end

    // Next-state logic
    always_comb
    begin
        state_next         = state_reg;
        clr_addr_next      = clr_addr_reg;
        hash_acc_next      = hash_acc_reg;
        s2_valid_next      = s2_valid_reg;
        s2_slot_next       = s2_slot_reg;
        fwd_hit_next       = fwd_hit_reg;
        fwd_data_next      = fwd_data_reg;
        total_next         = total_reg;
        unique_next        = unique_reg;
        best_count_next    = best_count_reg;
        best_slot_next     = best_slot_reg;
        out_valid_next     = out_valid_reg;
        out_slot_next      = out_slot_reg;
        out_count_next     = out_count_reg;
        out_first_next     = out_first_reg;
        out_total_next     = out_total_reg;
        out_unique_next    = out_unique_reg;
        out_top_count_next = out_top_count_reg;
        out_top_slot_next  = out_top_slot_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // Output register drains
                if (m_axis_tready)
                begin
                    out_valid_next = 1'b0;
                end

                // Result of the update stage moves to the output register
                if (s2_fire)
                begin
                    s2_valid_next      = 1'b0;
                    total_next         = total_upd;
                    unique_next        = unique_upd;
                    best_count_next    = best_count_upd;
                    best_slot_next     = best_slot_upd;
                    out_valid_next     = 1'b1;
                    out_slot_next      = s2_slot_reg;
                    out_count_next     = cnt_wide[OUT_CW-1:0];
                    out_first_next     = first;
                    out_total_next     = total_upd;
                    out_unique_next    = unique_upd;
                    out_top_count_next = best_wide[OUT_CW-1:0];
                    out_top_slot_next  = best_slot_upd;
                end

                // Character beat: advance hash, start a table read on token end
                if (in_fire)
                begin
                    if (s_axis_tlast)
                    begin
                        hash_acc_next = '0;
                        s2_valid_next = 1'b1;
                        s2_slot_next  = hash_new;
                        // catch a write to the same entry at the read edge
                        fwd_hit_next  = mem_we && (mem_waddr == mem_raddr);
                        fwd_data_next = mem_wdata;
                    end
                    else
                    begin
                        hash_acc_next = hash_new;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            hash_acc_reg   <= '0;
            s2_valid_reg   <= 1'b0;
            total_reg      <= '0;
            unique_reg     <= '0;
            best_count_reg <= '0;
            best_slot_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            hash_acc_reg   <= hash_acc_next;
            s2_valid_reg   <= s2_valid_next;
            total_reg      <= total_next;
            unique_reg     <= unique_next;
            best_count_reg <= best_count_next;
            best_slot_reg  <= best_slot_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s2_slot_reg       <= s2_slot_next;
        fwd_hit_reg       <= fwd_hit_next;
        fwd_data_reg      <= fwd_data_next;
        out_slot_reg      <= out_slot_next;
        out_count_reg     <= out_count_next;
        out_first_reg     <= out_first_next;
        out_total_reg     <= out_total_next;
        out_unique_reg    <= out_unique_next;
        out_top_count_reg <= out_top_count_next;
        out_top_slot_reg  <= out_top_slot_next;
    end

    // Output packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_first_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_top_slot_reg, out_top_count_reg, out_unique_reg,
                                         out_total_reg, out_count_reg, out_slot_reg});

`ifndef SYNTH
    // No character is taken while the table is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !running |-> !s_axis_tready)
        else $error("input accepted during table clear");

    // A stalled update stage keeps its token
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_stall |=> s2_valid_reg && $stable(s2_slot_reg))
        else $error("update stage lost its token while stalled");

    // First sighting always reports a count of one
    a_first_is_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_first_reg |-> out_count_reg == OUT_CW'(1))
        else $error("first_seen with count other than one");

    // The top record never lags the reported slot count
    a_top_ge_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_top_count_reg >= out_count_reg)
        else $error("top count below slot count");

    // Unique slots never outnumber tokens
    a_unique_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        running |-> TOTAL_W'(unique_reg) <= total_reg)
        else $error("unique count exceeds token total");
`endif

endmodule

### tb/testbench.sv
module testbench;
    import hth_pkg::*;

    localparam int HASH_MUL    = 54;
    localparam int RAND_ITEMS  = 1630;
    localparam int CALM_ITEMS  = 250;
    // clearing pass accepts nothing while it walks the table; allow it several times over
    localparam int STALL_LIMIT = 3 * TABLE_DEPTH + 5000;

    // Field offsets inside m_axis_tdata
    localparam int HITS_LO  = SLOT_W;
    localparam int TOTAL_LO = HITS_LO + OUT_CW;
    localparam int UNIQ_LO  = TOTAL_LO + TOTAL_W;
    localparam int TOPC_LO  = UNIQ_LO + UNIQUE_W;
    localparam int TOPS_LO  = TOPC_LO + OUT_CW;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [OUT_CW-1:0]   hits;
        logic                first;
        logic [TOTAL_W-1:0]  total;
        logic [UNIQUE_W-1:0] uniq;
        logic [OUT_CW-1:0]   top_hits;
        logic [SLOT_W-1:0]   top_slot;
    } token_stat_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              typed;
        token_stat_t       want;
    } dir_row_t;

    localparam int DIR_ROWS = 20;

    // Directed stimulus; typed rows carry their result, the rest go through the predictor
    dir_row_t dir_tab [DIR_ROWS] = '{
        // single-char tokens right after reset: extremes of the character
        '{8'd0,   1'b1, 1'b1, '{17'd0,   24'd1, 1'b1, 32'd1, 17'd1, 24'd1, 17'd0}},
        '{8'd255, 1'b1, 1'b1, '{17'd255, 24'd1, 1'b1, 32'd2, 17'd2, 24'd1, 17'd0}},
        // repeat raises the count, record moves to 2
        '{8'd0,   1'b1, 1'b1, '{17'd0,   24'd2, 1'b0, 32'd3, 17'd2, 24'd2, 17'd0}},
        // equal count does not take over the record
        '{8'd255, 1'b1, 1'b1, '{17'd255, 24'd2, 1'b0, 32'd4, 17'd2, 24'd2, 17'd0}},
        '{8'd255, 1'b1, 1'b1, '{17'd255, 24'd3, 1'b0, 32'd5, 17'd2, 24'd3, 17'd255}},
        // long token of max characters, wraps the modulus
        '{8'd255, 1'b0, 1'b0, '0},
        '{8'd255, 1'b0, 1'b0, '0},
        '{8'd255, 1'b0, 1'b0, '0},
        '{8'd255, 1'b1, 1'b0, '0},
        '{8'd97,  1'b0, 1'b0, '0},
        '{8'd98,  1'b1, 1'b0, '0},
        // zero characters hash back to slot 0
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   1'b1, 1'b0, '0},
        '{8'h55,  1'b0, 1'b0, '0},
        '{8'hAA,  1'b1, 1'b0, '0},
        '{8'hAA,  1'b0, 1'b0, '0},
        '{8'h55,  1'b1, 1'b0, '0},
        '{8'd128, 1'b1, 1'b0, '0},
        '{8'd1,   1'b1, 1'b0, '0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    // Predictor state
    int unsigned            hash_run;
    bit [COUNT_WIDTH-1:0]   slot_hits [TABLE_DEPTH];
    bit [TOTAL_W-1:0]       tok_run;
    bit [UNIQUE_W-1:0]      uniq_run;
    bit [COUNT_WIDTH-1:0]   best_hits;
    bit [SLOT_W-1:0]        best_slot;

    token_stat_t            pending_stats [$];
    int                     fails;
    int                     idle_cycles;
    bit                     calm;

    hashed_token_histogram_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hash one character; on token end update the histogram and build the result
    task automatic hash_and_tally(input logic [CHAR_W-1:0] ch, input logic last,
                                  output token_stat_t st);
        int unsigned          mixed;
        bit [COUNT_WIDTH-1:0] n;
        mixed    = hash_run * HASH_MUL + ch;
        hash_run = mixed % HASH_MOD;
        st       = '0;
        if (last)
        begin
            n = slot_hits[hash_run];
            if (n != '1)
            begin
                n++;
                slot_hits[hash_run] = n;
                if (n == 1)
                begin
                    st.first = 1'b1;
                    uniq_run++;
                end
            end
            if (tok_run != '1)
                tok_run++;
            if (n > best_hits)
            begin
                best_hits = n;
                best_slot = SLOT_W'(hash_run);
            end
            st.slot     = SLOT_W'(hash_run);
            st.hits     = OUT_CW'(n);
            st.total    = tok_run;
            st.uniq     = uniq_run;
            st.top_hits = OUT_CW'(best_hits);
            st.top_slot = best_slot;
            hash_run    = 0;
        end
    endtask

    // Drive one character beat; called at a falling edge, returns at a falling edge
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last,
                             input logic typed, input token_stat_t want);
        token_stat_t st;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        hash_and_tally(ch, last, st);
        if (last)
            pending_stats.push_back(typed ? want : st);
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin : result_check
        token_stat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_stats.size() == 0)
            begin
                fails++;
                $display("%0t: unexpected result beat, expected none, actual slot %0d",
                         $time, m_axis_tdata[SLOT_W-1:0]);
            end
            else
            begin
                want = pending_stats.pop_front();
                check_field("slot", 32'(want.slot), 32'(m_axis_tdata[HITS_LO-1:0]));
                check_field("slot_count", 32'(want.hits),
                            32'(m_axis_tdata[TOTAL_LO-1:HITS_LO]));
                check_field("first_seen", 32'(want.first), 32'(m_axis_tuser));
                check_field("total_tokens", want.total, m_axis_tdata[UNIQ_LO-1:TOTAL_LO]);
                check_field("unique_tokens", 32'(want.uniq),
                            32'(m_axis_tdata[TOPC_LO-1:UNIQ_LO]));
                check_field("top_count", 32'(want.top_hits),
                            32'(m_axis_tdata[TOPS_LO-1:TOPC_LO]));
                check_field("top_slot", 32'(want.top_slot),
                            32'(m_axis_tdata[TOPS_LO+SLOT_W-1:TOPS_LO]));
            end
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Receiver: ready runs and stall bursts, always ready once calm
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (calm || $urandom_range(0, 3) != 0)
            begin
                m_axis_tready <= 1'b1;
                if (!calm)
                    repeat ($urandom_range(1, 20) - 1) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge clk);
            end
        end
    end

    // Main sequence
    initial
    begin : main_seq
        int          sent;
        int          len;
        bit          narrow;
        bit          paused;
        logic [7:0]  ch;
        hash_run    = 0;
        tok_run     = '0;
        uniq_run    = '0;
        best_hits   = '0;
        best_slot   = '0;
        fails       = 0;
        idle_cycles = 0;
        calm        = 1'b0;
        sent        = 0;
        paused      = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
            send_char(dir_tab[i].ch, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);

        // random tokens; narrow alphabet gives many repeats and record changes
        while (sent < RAND_ITEMS)
        begin
            if (!paused && sent >= RAND_ITEMS / 2)
            begin
                // hold off until every pending result has drained
                s_axis_tvalid <= 1'b0;
                while (pending_stats.size() != 0)
                    @(negedge clk);
                @(negedge clk);
                paused = 1'b1;
            end
            calm   = (sent >= RAND_ITEMS - CALM_ITEMS);
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            narrow = ($urandom_range(0, 2) != 0);
            for (int k = 0; k < len; k++)
            begin
                ch = narrow ? 8'($urandom_range(97, 100)) : 8'($urandom_range(0, 255));
                send_char(ch, k == len - 1, 1'b0, '0);
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
